FILE: sv/keyword_cipher_decrypt_assert.svh
// Assertion macros for the keyword cipher decrypt controller.
`ifndef KEYWORD_CIPHER_DECRYPT_ASSERT_SVH
`define KEYWORD_CIPHER_DECRYPT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define KCD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define KCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/kcd_pkg.sv
// Types and constants for the keyword cipher decrypt block.
`default_nettype none

package kcd_pkg;

  localparam int LETTERS  = 26;
  localparam int LETTER_W = 5;

  localparam logic [7:0] CHAR_LA     = 8'h61;  // 'a'
  localparam logic [7:0] CHAR_LZ     = 8'h7a;  // 'z'
  localparam logic [7:0] CHAR_UA     = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_UZ     = 8'h5a;  // 'Z'
  localparam logic [7:0] CASE_OFFSET = 8'h20;  // 'a' - 'A'

  localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(LETTERS - 1);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic kw_load;    // keyword word accepted
    logic kw_last;    // ... and it closes the keyword
    logic txt_load;   // ciphertext word accepted, load result register
    logic fill_step;  // one step of the key alphabet fill
  } cmd_t;

endpackage

`default_nettype wire

FILE: sv/kcd_dpath.sv
// Datapath: key table, keyword tracking state, fill pointer and result register.
`default_nettype none

module kcd_dpath (
  input  wire              clk,
  input  wire              rst_n,
  input  kcd_pkg::cmd_t    cmd,
  input  wire  [7:0]       in_data_char,
  output logic [7:0]       out_plain_char
);

  logic [kcd_pkg::LETTER_W-1:0] key_pos_r [kcd_pkg::LETTERS];
  logic [kcd_pkg::LETTERS-1:0]  used_r;
  logic [kcd_pkg::LETTER_W-1:0] next_pos_r;
  logic [kcd_pkg::LETTER_W-1:0] last_new_r;
  logic                         building_r;
  logic                         any_kw_r;
  logic [kcd_pkg::LETTER_W-1:0] fill_letter_r;
  logic [7:0]                   plain_r;

  logic                         is_upper;
  logic [7:0]                   lc_char;
  logic                         is_letter;
  logic [kcd_pkg::LETTER_W-1:0] idx;

  // keyword state as seen by this word (cleared at the start of a keyword)
  logic [kcd_pkg::LETTERS-1:0]  base_used;
  logic [kcd_pkg::LETTER_W-1:0] base_pos;
  logic [kcd_pkg::LETTER_W-1:0] base_last;
  logic                         base_any;
  logic                         new_letter;
  logic [kcd_pkg::LETTER_W-1:0] last_nxt;
  logic                         any_nxt;
  logic [kcd_pkg::LETTER_W-1:0] fill_start;
  logic                         fill_place;
  logic [7:0]                   plain_nxt;

  always_comb begin
    is_upper  = (in_data_char >= kcd_pkg::CHAR_UA) && (in_data_char <= kcd_pkg::CHAR_UZ);
    lc_char   = is_upper ? in_data_char + kcd_pkg::CASE_OFFSET : in_data_char;
    is_letter = (lc_char >= kcd_pkg::CHAR_LA) && (lc_char <= kcd_pkg::CHAR_LZ);
    idx       = kcd_pkg::LETTER_W'(lc_char - kcd_pkg::CHAR_LA);

    base_used = building_r ? used_r     : '0;
    base_pos  = building_r ? next_pos_r : '0;
    base_last = building_r ? last_new_r : '0;
    base_any  = building_r && any_kw_r;

    new_letter = is_letter && !base_used[idx];
    last_nxt   = new_letter ? idx : base_last;
    any_nxt    = base_any || new_letter;

    if (!any_nxt) begin
      fill_start = '0;
    end else if (last_nxt == kcd_pkg::LAST_LETTER) begin
      fill_start = '0;
    end else begin
      fill_start = last_nxt + kcd_pkg::LETTER_W'(1);
    end

    fill_place = !used_r[fill_letter_r];

    if (is_letter) begin
      plain_nxt = (is_upper ? kcd_pkg::CHAR_UA : kcd_pkg::CHAR_LA) + {3'b000, key_pos_r[idx]};
    end else begin
      plain_nxt = in_data_char;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < kcd_pkg::LETTERS; i++) begin
        key_pos_r[i] <= kcd_pkg::LETTER_W'(i);
      end
      used_r        <= '0;
      next_pos_r    <= '0;
      last_new_r    <= '0;
      building_r    <= 1'b0;
      any_kw_r      <= 1'b0;
      fill_letter_r <= '0;
    end else if (cmd.kw_load) begin
      if (new_letter) begin
        key_pos_r[idx] <= base_pos;
        used_r         <= base_used | (kcd_pkg::LETTERS'(1) << idx);
        next_pos_r     <= base_pos + kcd_pkg::LETTER_W'(1);
      end else begin
        used_r     <= base_used;
        next_pos_r <= base_pos;
      end
      last_new_r    <= last_nxt;
      any_kw_r      <= any_nxt;
      building_r    <= !cmd.kw_last;
      fill_letter_r <= fill_start;
    end else if (cmd.fill_step) begin
      if (fill_place) begin
        key_pos_r[fill_letter_r] <= next_pos_r;
        used_r[fill_letter_r]    <= 1'b1;
        next_pos_r               <= next_pos_r + kcd_pkg::LETTER_W'(1);
      end
      fill_letter_r <= (fill_letter_r == kcd_pkg::LAST_LETTER) ? '0
                     : fill_letter_r + kcd_pkg::LETTER_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.txt_load) begin
      plain_r <= plain_nxt;
    end
  end

  assign out_plain_char = plain_r;

endmodule

`default_nettype wire

FILE: sv/kcd_ctrl.sv
// Controller: handshakes, fill sequencing and result-register valid.
`default_nettype none

module kcd_ctrl (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  input  wire            in_kind,
  input  wire            in_keyword_last,
  output logic           in_ready,
  output logic           out_valid,
  input  wire            out_ready,
  output kcd_pkg::cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_FILL
  } state_t;

  state_t                       state_r, state_nxt;
  logic [kcd_pkg::LETTER_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         accept;

  always_comb begin
    in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
    accept   = in_valid && in_ready;

    cmd.kw_load   = accept && !in_kind;
    cmd.kw_last   = accept && !in_kind && in_keyword_last;
    cmd.txt_load  = accept && in_kind;
    cmd.fill_step = (state_r == ST_FILL);

    state_nxt     = state_r;
    fill_cnt_nxt  = fill_cnt_r;
    out_valid_nxt = out_valid_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.txt_load) begin
      out_valid_nxt = 1'b1;
    end

    case (state_r)
      ST_IDLE: begin
        if (cmd.kw_last) begin
          state_nxt    = ST_FILL;
          fill_cnt_nxt = '0;
        end
      end
      ST_FILL: begin
        // one pass over the whole alphabet
        if (fill_cnt_r == kcd_pkg::LAST_LETTER) begin
          state_nxt = ST_IDLE;
        end
        fill_cnt_nxt = fill_cnt_r + kcd_pkg::LETTER_W'(1);
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`include "keyword_cipher_decrypt_assert.svh"

  `KCD_ASSERT_NOW(a_fill_blocks_input, state_r == ST_FILL, !in_ready, "input taken during fill")
  `KCD_ASSERT_NEXT(a_last_starts_fill, cmd.kw_last, state_r == ST_FILL, "fill did not start")
  `KCD_ASSERT_NEXT(a_fill_runs, (state_r == ST_FILL) && (fill_cnt_r != kcd_pkg::LAST_LETTER), (state_r == ST_FILL) && (fill_cnt_r == $past(fill_cnt_r) + kcd_pkg::LETTER_W'(1)), "fill cut short")
  `KCD_ASSERT_NEXT(a_text_gives_word, cmd.txt_load, out_valid_r, "no result for text word")

endmodule

`default_nettype wire

FILE: sv/keyword_cipher_decrypt.sv
// Keyword substitution cipher decryptor: top level.
// Input channel (in_valid/in_ready): in_kind 0 carries a keyword character,
// in_kind 1 a ciphertext character; in_keyword_last marks the final keyword
// character. Keyword letters are case folded, each unseen letter takes the next
// key position, non-letters are skipped.
// Output channel (out_valid/out_ready): one word per ciphertext character,
// out_plain_char, the decrypted letter in the same case or the byte unchanged.
// Keyword words make no output.
// Latency: a ciphertext word shows on the output the cycle after acceptance.
// Throughput: one word per cycle while the receiver keeps up; a keyword word with
// in_keyword_last set is followed by the key alphabet fill, one letter per cycle,
// from the letter after the last new keyword letter, during which in_ready is low.
// A single output register holds the result; while the receiver stalls it,
// in_ready is low and the next word of either kind waits until it is taken.
// Reset (rst_n low, synchronous) gives the identity key and an empty output.
`default_nettype none

module keyword_cipher_decrypt (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        in_kind,
  input  wire  [7:0] in_data_char,
  input  wire        in_keyword_last,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_plain_char
);

  kcd_pkg::cmd_t cmd;

  kcd_ctrl u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_kind         (in_kind),
    .in_keyword_last (in_keyword_last),
    .in_ready        (in_ready),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .cmd             (cmd)
  );

  kcd_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_data_char   (in_data_char),
    .out_plain_char (out_plain_char)
  );

endmodule

`default_nettype wire
